FILE: rtl/assert_macros.svh
// assertion macros shared by the decoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/u8d_pkg.sv
// types and constants shared by the utf-8 stream decoder
package u8d_pkg;

    localparam int CP_W = 21;

    localparam logic [CP_W-1:0] C_REPLACEMENT = 21'h00FFFD;
    localparam logic [CP_W-1:0] C_MIN_2       = 21'h000080;
    localparam logic [CP_W-1:0] C_MIN_3       = 21'h000800;
    localparam logic [CP_W-1:0] C_MIN_4       = 21'h010000;
    localparam logic [CP_W-1:0] C_SURR_LO     = 21'h00D800;
    localparam logic [CP_W-1:0] C_SURR_HI     = 21'h00DFFF;
    localparam logic [CP_W-1:0] C_MAX_CP      = 21'h10FFFF;
    localparam logic [CP_W-1:0] C_LF          = 21'h00000A;
    localparam logic [CP_W-1:0] C_CR          = 21'h00000D;

    localparam logic [7:0] C_MASK_2  = 8'hE0;
    localparam logic [7:0] C_LEAD_2  = 8'hC0;
    localparam logic [7:0] C_MASK_3  = 8'hF0;
    localparam logic [7:0] C_LEAD_3  = 8'hE0;
    localparam logic [7:0] C_MASK_4  = 8'hF8;
    localparam logic [7:0] C_LEAD_4  = 8'hF0;
    localparam logic [7:0] C_CONT_MASK = 8'hC0;
    localparam logic [7:0] C_CONT_TAG  = 8'h80;

    // one evaluation of the sequence at the head of the buffer
    typedef struct packed {
        logic            emit;   // a result comes out of this step
        logic            stop;   // nothing more to decode for this request
        logic            clear;  // drop every buffered byte
        logic [2:0]      drop;   // bytes to remove from the front
        logic [CP_W-1:0] cp;
        logic            repl;
    } t_step;

endpackage

FILE: rtl/u8d_step_unit.sv
// decode and validation of the sequence at the head of the byte buffer
module u8d_step_unit
    import u8d_pkg::*;
(
    input  logic [3:0][7:0] i_bytes,
    input  logic [2:0]      i_cnt,
    input  logic            i_eot,
    output t_step           o_step
);

    logic [7:0]      lead;
    logic [2:0]      len;
    logic            lead_bad;
    logic [3:1]      cont_ok;
    logic [CP_W-1:0] cp2;
    logic [CP_W-1:0] cp3;
    logic [CP_W-1:0] cp4;
    logic [CP_W-1:0] cp_sel;
    logic            form_ok;
    logic            seq_ok;

    assign lead = i_bytes[0];

    always_comb begin
        len      = 3'd1;
        lead_bad = 1'b0;
        if (!lead[7]) begin
            len = 3'd1;
        end else if ((lead & C_MASK_2) == C_LEAD_2) begin
            len = 3'd2;
        end else if ((lead & C_MASK_3) == C_LEAD_3) begin
            len = 3'd3;
        end else if ((lead & C_MASK_4) == C_LEAD_4) begin
            len = 3'd4;
        end else begin
            lead_bad = 1'b1;
        end
    end

    always_comb begin
        for (int j = 1; j < 4; j++) begin
            cont_ok[j] = (i_bytes[j] & C_CONT_MASK) == C_CONT_TAG;
        end
    end

    assign cp2 = {10'd0, lead[4:0], i_bytes[1][5:0]};
    assign cp3 = {5'd0, lead[3:0], i_bytes[1][5:0], i_bytes[2][5:0]};
    assign cp4 = {lead[2:0], i_bytes[1][5:0], i_bytes[2][5:0], i_bytes[3][5:0]};

    always_comb begin
        case (len)
            3'd2: begin
                cp_sel  = cp2;
                form_ok = cont_ok[1] && (cp2 >= C_MIN_2);
            end
            3'd3: begin
                cp_sel  = cp3;
                form_ok = cont_ok[1] && cont_ok[2] && (cp3 >= C_MIN_3);
            end
            3'd4: begin
                cp_sel  = cp4;
                form_ok = cont_ok[1] && cont_ok[2] && cont_ok[3] && (cp4 >= C_MIN_4);
            end
            default: begin
                cp_sel  = {14'd0, lead[6:0]};
                form_ok = 1'b1;
            end
        endcase
    end

    assign seq_ok = form_ok && !((cp_sel >= C_SURR_LO) && (cp_sel <= C_SURR_HI))
                    && (cp_sel <= C_MAX_CP);

    always_comb begin
        o_step       = '0;
        o_step.cp    = C_REPLACEMENT;
        o_step.repl  = 1'b1;
        if (i_cnt == 3'd0) begin
            o_step.stop = 1'b1;
        end else if (lead_bad) begin
            o_step.emit = 1'b1;
            o_step.drop = 3'd1;
        end else if (len > i_cnt) begin
            // incomplete sequence: flushed as one replacement at end of text
            o_step.stop = 1'b1;
            if (i_eot) begin
                o_step.emit  = 1'b1;
                o_step.clear = 1'b1;
            end
        end else if (seq_ok) begin
            o_step.emit = 1'b1;
            o_step.drop = len;
            o_step.cp   = cp_sel;
            o_step.repl = 1'b0;
        end else begin
            o_step.emit = 1'b1;
            o_step.drop = 3'd1;
        end
    end

endmodule

FILE: rtl/utf8_stream_decoder_unit.sv
// top level of the utf-8 stream decoder: byte buffer, sequencer and output register
//
// Takes one byte per request and emits zero to four decoded code points, U+FFFD
// standing in for malformed input. A byte is accepted only while the block is idle;
// each request then runs until its last result is in the output register, stalling
// while the output side does. The single step unit decodes one buffered sequence
// per cycle while no result is held or the output register is free; the sequencer
// holds the last result back until it learns that it closes the request (run_last).
// Up to three bytes of an unfinished sequence stay buffered between requests;
// a byte with tlast set flushes them. Output tlast marks the final result of a text.
`include "assert_macros.svh"

module utf8_stream_decoder_unit
    import u8d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] code_point, [21] run_last, [23:22] zero
    output logic [1:0]  m_axis_tuser,   // [0] is_replacement, [1] renderable
    output logic        m_axis_tlast    // text_last
);

    typedef enum logic {S_IDLE, S_RUN} t_state;

    t_state          r_state, n_state;
    logic [3:0][7:0] r_buf, n_buf;
    logic [2:0]      r_cnt, n_cnt;
    logic            r_eot, n_eot;
    logic            r_have, n_have;
    logic [CP_W-1:0] r_hold_cp, n_hold_cp;
    logic            r_hold_repl, n_hold_repl;
    logic            r_out_valid, n_out_valid;
    logic [CP_W-1:0] r_out_cp, n_out_cp;
    logic            r_out_repl, n_out_repl;
    logic            r_out_rend, n_out_rend;
    logic            r_out_run_last, n_out_run_last;
    logic            r_out_text_last, n_out_text_last;

    t_step           step;
    logic            out_free;
    logic [3:0][7:0] shifted;

    u8d_step_unit u_step (
        .i_bytes (r_buf),
        .i_cnt   (r_cnt),
        .i_eot   (r_eot),
        .o_step  (step)
    );

    assign out_free = !r_out_valid || m_axis_tready;
    assign shifted  = r_buf >> {step.drop, 3'b000};

    always_comb begin
        n_state         = r_state;
        n_buf           = r_buf;
        n_cnt           = r_cnt;
        n_eot           = r_eot;
        n_have          = r_have;
        n_hold_cp       = r_hold_cp;
        n_hold_repl     = r_hold_repl;
        n_out_valid     = r_out_valid && !m_axis_tready;
        n_out_cp        = r_out_cp;
        n_out_repl      = r_out_repl;
        n_out_rend      = r_out_rend;
        n_out_run_last  = r_out_run_last;
        n_out_text_last = r_out_text_last;

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_buf[r_cnt[1:0]] = s_axis_tdata;
                    n_cnt             = r_cnt + 3'd1;
                    n_eot             = s_axis_tlast;
                    n_state           = S_RUN;
                end
            end
            S_RUN: begin
                if (step.emit) begin
                    if (!r_have || out_free) begin
                        // the held result is known not to be the last one
                        if (r_have) begin
                            n_out_valid     = 1'b1;
                            n_out_cp        = r_hold_cp;
                            n_out_repl      = r_hold_repl;
                            n_out_rend      = (r_hold_cp != C_LF) && (r_hold_cp != C_CR);
                            n_out_run_last  = 1'b0;
                            n_out_text_last = 1'b0;
                        end
                        n_have      = 1'b1;
                        n_hold_cp   = step.cp;
                        n_hold_repl = step.repl;
                        n_buf       = shifted;
                        if (step.clear || ({1'b0, step.drop} >= {1'b0, r_cnt})) begin
                            n_cnt = 3'd0;
                        end else begin
                            n_cnt = r_cnt - step.drop;
                        end
                    end
                end else if (!r_have) begin
                    n_state = S_IDLE;
                    if (r_eot) begin
                        n_cnt = 3'd0;
                    end
                end else if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out_cp        = r_hold_cp;
                    n_out_repl      = r_hold_repl;
                    n_out_rend      = (r_hold_cp != C_LF) && (r_hold_cp != C_CR);
                    n_out_run_last  = 1'b1;
                    n_out_text_last = r_eot;
                    n_have          = 1'b0;
                    n_state         = S_IDLE;
                    if (r_eot) begin
                        n_cnt = 3'd0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_buf           <= n_buf;
        r_eot           <= n_eot;
        r_hold_cp       <= n_hold_cp;
        r_hold_repl     <= n_hold_repl;
        r_out_cp        <= n_out_cp;
        r_out_repl      <= n_out_repl;
        r_out_rend      <= n_out_rend;
        r_out_run_last  <= n_out_run_last;
        r_out_text_last <= n_out_text_last;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= 3'd0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_have      <= n_have;
            r_out_valid <= n_out_valid;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_run_last, r_out_cp};
    assign m_axis_tuser  = {r_out_rend, r_out_repl};
    assign m_axis_tlast  = r_out_text_last;

    `ASSERT_IMPLY(a_room_on_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !r_cnt[2])

    `ASSERT_IMPLY(a_hold_only_in_run, i_clk, i_rst_n, r_have, r_state == S_RUN)

    `ASSERT_IMPLY(a_text_end_closes_run, i_clk, i_rst_n, r_out_valid && r_out_text_last, r_out_run_last)

    `ASSERT_NEXT(a_text_end_empties, i_clk, i_rst_n, (r_state == S_RUN) && !step.emit && r_eot && (!r_have || out_free), (r_cnt == 3'd0) && (r_state == S_IDLE))

endmodule

FILE: bench/utf8_stream_decoder_unit_tb.sv
// testbench for the utf-8 stream decoder: directed table and random byte streams
`timescale 1ns / 1ps

module utf8_stream_decoder_unit_tb;
    import u8d_pkg::*;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            repl;
        logic            rend;
        logic            run_last;
        logic            text_last;
    } t_cp_res;

    typedef struct {
        logic [7:0] b;
        logic       eot;
        bit         typed;
        t_cp_res    res;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic        s_axis_tlast = 1'b0;    // end_of_text
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;           // [20:0] code_point, [21] run_last, [23:22] zero
    logic [1:0]  m_axis_tuser;           // [0] is_replacement, [1] renderable
    logic        m_axis_tlast;           // text_last

    // decoder state as the software side sees it
    logic [7:0] held_bytes [4] = '{default: 8'h00};
    int         held_cnt = 0;

    t_cp_res step_res [$];
    t_cp_res want_q [$];
    int      fail_cnt = 0;
    int      sink_hold = 0;
    logic    calm = 1'b0;

    // directed rows; a typed row expects exactly the one result given
    t_dir_row dir_tab [26] = '{
        '{8'h00, 1'b0, 1'b1, '{21'h000000, 1'b0, 1'b1, 1'b1, 1'b0}},
        '{8'h7F, 1'b1, 1'b1, '{21'h00007F, 1'b0, 1'b1, 1'b1, 1'b1}},
        '{8'h0A, 1'b0, 1'b1, '{C_LF,       1'b0, 1'b0, 1'b1, 1'b0}},
        '{8'h0D, 1'b1, 1'b1, '{C_CR,       1'b0, 1'b0, 1'b1, 1'b1}},
        '{8'h80, 1'b0, 1'b1, '{C_REPLACEMENT, 1'b1, 1'b1, 1'b1, 1'b0}},
        '{8'hFF, 1'b0, 1'b1, '{C_REPLACEMENT, 1'b1, 1'b1, 1'b1, 1'b0}},
        '{8'hC2, 1'b0, 1'b0, '0},
        '{8'h80, 1'b0, 1'b0, '0},
        // overlong two-byte form
        '{8'hC0, 1'b0, 1'b0, '0},
        '{8'h80, 1'b0, 1'b0, '0},
        '{8'hE0, 1'b0, 1'b0, '0},
        '{8'hA0, 1'b0, 1'b0, '0},
        '{8'h80, 1'b0, 1'b0, '0},
        // surrogate
        '{8'hED, 1'b0, 1'b0, '0},
        '{8'hA0, 1'b0, 1'b0, '0},
        '{8'h80, 1'b0, 1'b0, '0},
        '{8'hF4, 1'b0, 1'b0, '0},
        '{8'h8F, 1'b0, 1'b0, '0},
        '{8'hBF, 1'b0, 1'b0, '0},
        '{8'hBF, 1'b0, 1'b0, '0},
        // above the top of the code space, four results
        '{8'hF7, 1'b0, 1'b0, '0},
        '{8'hBF, 1'b0, 1'b0, '0},
        '{8'hBF, 1'b0, 1'b0, '0},
        '{8'hBF, 1'b0, 1'b0, '0},
        // text ends mid-sequence
        '{8'hE2, 1'b0, 1'b0, '0},
        '{8'h82, 1'b1, 1'b1, '{C_REPLACEMENT, 1'b1, 1'b1, 1'b1, 1'b1}}
    };

    utf8_stream_decoder_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        else if (r < 85) return $urandom_range(1, 2);
        else if (r < 95) return $urandom_range(3, 8);
        else return $urandom_range(20, 40);
    endfunction

    // decode one byte into step_res and advance the held state
    task automatic decode_byte(input logic [7:0] b, input logic eot);
        logic [7:0]  lead;
        logic [7:0]  c;
        int unsigned cpv;
        int          len;
        int          drop;
        bit          ok;
        bit          emit;
        bit          held_wait;
        t_cp_res     r;
        step_res.delete();
        held_bytes[held_cnt] = b;
        held_cnt++;
        held_wait = 0;
        while (held_cnt > 0 && step_res.size() < 4 && !held_wait) begin
            lead = held_bytes[0];
            ok = 1;
            emit = 1;
            len = 0;
            cpv = 0;
            if (lead[7] == 1'b0) begin
                cpv = lead;
                len = 1;
            end else if ((lead & C_MASK_2) == C_LEAD_2) begin
                cpv = lead & 8'h1F;
                len = 2;
            end else if ((lead & C_MASK_3) == C_LEAD_3) begin
                cpv = lead & 8'h0F;
                len = 3;
            end else if ((lead & C_MASK_4) == C_LEAD_4) begin
                cpv = lead & 8'h07;
                len = 4;
            end
            if (len == 0) begin
                ok = 0;
            end else if (len > held_cnt) begin
                // incomplete: wait for more, or flush as one replacement at end of text
                held_wait = 1;
                ok = 0;
                emit = eot;
            end else begin
                for (int i = 1; i < len; i++) begin
                    c = held_bytes[i];
                    if ((c & C_CONT_MASK) != C_CONT_TAG) ok = 0;
                    cpv = (cpv << 6) | (c & 8'h3F);
                end
                if ((len == 2 && cpv < C_MIN_2) || (len == 3 && cpv < C_MIN_3) ||
                    (len == 4 && cpv < C_MIN_4))
                    ok = 0;
                if (cpv >= C_SURR_LO && cpv <= C_SURR_HI) ok = 0;
                if (cpv > C_MAX_CP) ok = 0;
            end
            if (emit) begin
                r.cp = ok ? cpv[CP_W-1:0] : C_REPLACEMENT;
                r.repl = !ok;
                r.rend = (r.cp != C_LF) && (r.cp != C_CR);
                r.run_last = 1'b0;
                r.text_last = 1'b0;
                step_res.insert(step_res.size(), r);
            end
            if (!held_wait) begin
                drop = ok ? len : 1;
                for (int k = 0; k < 4; k++)
                    held_bytes[k] = (k + drop < 4) ? held_bytes[k + drop] : 8'h00;
                held_cnt -= drop;
            end
        end
        if (eot) held_cnt = 0;
        if (step_res.size() > 0) begin
            step_res[step_res.size() - 1].run_last = 1'b1;
            step_res[step_res.size() - 1].text_last = eot;
        end
    endtask

    // present one byte, wait for the request to be taken, then record what it should give
    task automatic send_byte(input logic [7:0] b, input logic eot, input bit typed,
                             input t_cp_res typed_res);
        int g;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= eot;
        do @(posedge i_clk); while (!s_axis_tready);
        decode_byte(b, eot);
        if (typed) want_q.insert(want_q.size(), typed_res);
        else foreach (step_res[i]) want_q.insert(want_q.size(), step_res[i]);
        g = calm ? 0 : gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        int n;
        if (calm) begin
            m_axis_tready <= 1'b1;
        end else if (sink_hold > 0) begin
            sink_hold--;
            m_axis_tready <= 1'b0;
        end else begin
            n = gap_len();
            m_axis_tready <= (n == 0);
            if (n > 0) sink_hold = n - 1;
        end
    end

    always @(posedge i_clk) begin
        t_cp_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (want_q.size() == 0) begin
                $error("unexpected result: code_point %h", m_axis_tdata[20:0]);
                fail_cnt++;
            end else begin
                want = want_q.pop_front();
                if (m_axis_tdata[20:0] !== want.cp) begin
                    $error("code_point: expected %h, got %h", want.cp, m_axis_tdata[20:0]);
                    fail_cnt++;
                end
                if (m_axis_tuser[0] !== want.repl) begin
                    $error("is_replacement: expected %b, got %b", want.repl, m_axis_tuser[0]);
                    fail_cnt++;
                end
                if (m_axis_tuser[1] !== want.rend) begin
                    $error("renderable: expected %b, got %b", want.rend, m_axis_tuser[1]);
                    fail_cnt++;
                end
                if (m_axis_tdata[21] !== want.run_last) begin
                    $error("run_last: expected %b, got %b", want.run_last, m_axis_tdata[21]);
                    fail_cnt++;
                end
                if (m_axis_tlast !== want.text_last) begin
                    $error("text_last: expected %b, got %b", want.text_last, m_axis_tlast);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        logic [7:0] seq_q [$];
        logic [7:0] lead_b;
        logic [7:0] bad;
        int         kind;
        int         len;
        int         sent;
        int unsigned cpv;
        bit         paused_once;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i])
            send_byte(dir_tab[i].b, dir_tab[i].eot, dir_tab[i].typed, dir_tab[i].res);

        sent = 0;
        paused_once = 0;
        while (sent < 84) begin
            // a stretch with neither side idling
            calm <= (sent >= 30 && sent < 55);
            seq_q.delete();
            kind = $urandom_range(0, 99);
            if (kind < 20) begin
                if ($urandom_range(0, 7) == 0)
                    seq_q.insert(seq_q.size(), $urandom_range(0, 1) ? 8'h0A : 8'h0D);
                else
                    seq_q.insert(seq_q.size(), 8'($urandom_range(0, 127)));
            end else if (kind < 92) begin
                if (kind < 35) begin
                    len = 2;
                    cpv = $urandom_range('h80, 'h7FF);
                end else if (kind < 50) begin
                    len = 3;
                    cpv = $urandom_range('h800, 'hFFFF);
                end else if (kind < 65) begin
                    len = 4;
                    cpv = $urandom_range('h10000, 'h10FFFF);
                end else if (kind < 72) begin
                    len = 4;
                    cpv = $urandom_range('h110000, 'h1FFFFF);
                end else if (kind < 80) begin
                    // overlong forms of small values
                    len = $urandom_range(2, 4);
                    cpv = $urandom_range(0, (len == 2) ? 'h7F : (len == 3) ? 'h7FF : 'hFFFF);
                end else begin
                    len = $urandom_range(2, 4);
                    cpv = $urandom & ((32'd1 << (5 * len + 1)) - 1);
                end
                lead_b = (len == 2) ? C_LEAD_2 : (len == 3) ? C_LEAD_3 : C_LEAD_4;
                seq_q.insert(seq_q.size(), lead_b | 8'(cpv >> (6 * (len - 1))));
                for (int i = 1; i < len; i++)
                    seq_q.insert(seq_q.size(),
                                 C_CONT_TAG | 8'((cpv >> (6 * (len - 1 - i))) & 'h3F));
                if (kind >= 80 && kind < 86) begin
                    repeat ($urandom_range(1, len - 1)) void'(seq_q.pop_back());
                end else if (kind >= 86) begin
                    bad = 8'($urandom);
                    if (bad[7:6] == 2'b10) bad[6] = 1'b1;
                    seq_q[$urandom_range(1, len - 1)] = bad;
                end
            end else begin
                repeat ($urandom_range(1, 3)) seq_q.insert(seq_q.size(), 8'($urandom));
            end
            foreach (seq_q[i]) begin
                send_byte(seq_q[i], $urandom_range(0, 14) == 0, 1'b0, '0);
                sent++;
            end
            if (!paused_once && sent >= 50) begin
                // hold off until the decoder has drained
                paused_once = 1;
                s_axis_tvalid <= 1'b0;
                while (want_q.size() != 0) @(posedge i_clk);
                @(posedge i_clk);
            end
        end
        // close the text so nothing stays held
        send_byte(8'h2E, 1'b1, 1'b0, '0);
        s_axis_tvalid <= 1'b0;

        while (want_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (fail_cnt == 0 && want_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
